### src/pbfas_pkg.sv
// Shared types and constants of the per-bar frame average smoother.
package pbfas_pkg;

    localparam int VAL_W = 8;
    localparam int IDX_W = 5;
    localparam int CFG_W = 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] ADDR_SMOOTHING_FRAMES = 3'd0;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

### src/per_bar_frame_average_smoother.sv
// Top level of the per-bar frame average smoother.
//
//   channel   direction  handshake                 contents
//   s_axis    in         tvalid/tready             bar_value, bar_index
//   m_axis    out        tvalid/tready             smoothed_value
//   apb       in/out     psel/penable/pready       smoothing_frames at 0x0
//
// A word is accepted, its history is read from the RAM and summed, the sum
// is divided and the result is written back; bypassed words skip the read,
// the divide and the write-back.
// After reset every entry of the history RAM is cleared, during which
// s_axis_tready stays low. A stalled output holds the block in its final
// state until the result is taken.
module per_bar_frame_average_smoother #(
    parameter int NUM_BARS   = 20,
    parameter int MAX_FRAMES = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [7:0] bar_value, [12:8] bar_index, [15:13] zero
    input  logic [15:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] smoothed_value
    output logic [7:0]                   m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbfas_pkg::APB_AW-1:0] paddr,
    input  logic [pbfas_pkg::APB_DW-1:0] pwdata,
    output logic [pbfas_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);

    import pbfas_pkg::*;

    localparam int DEPTH = MAX_FRAMES * NUM_BARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_FRAMES + 1);
    localparam int SW    = $clog2(MAX_FRAMES);
    localparam int SUM_W = $clog2(MAX_FRAMES * 255 + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_reg, cfg_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [AW-1:0]    slot_base_reg, slot_base_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0] bar_reg, bar_next;
    logic [KW-1:0]    n_reg, n_next;
    logic             pend_reg, pend_next;
    logic             pend_slot_reg, pend_slot_next;
    logic             bypass_reg, bypass_next;
    logic             last_bar_reg, last_bar_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_data_reg, out_data_next;

    logic [KW-1:0]    k_eff;
    logic             accept_in;
    logic             out_free;
    logic [VAL_W-1:0] in_val;
    logic [IDX_W-1:0] in_idx;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    logic             div_start;
    logic             div_done;
    logic [VAL_W-1:0] div_q;

    assign in_val    = s_axis_tdata[VAL_W-1:0];
    assign in_idx    = s_axis_tdata[VAL_W+IDX_W-1:VAL_W];
    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (32'(cfg_reg) > 32'(MAX_FRAMES))
        begin
            k_eff = KW'(MAX_FRAMES);
        end
        else
        begin
            k_eff = KW'(cfg_reg);
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready && paddr == ADDR_SMOOTHING_FRAMES)
        begin
            cfg_next = pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SMOOTHING_FRAMES) ? APB_DW'(cfg_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        slot_base_next = slot_base_reg;
        clr_addr_next  = clr_addr_reg;
        addr_next      = addr_reg;
        bar_next       = bar_reg;
        n_next         = n_reg;
        pend_next      = 1'b0;
        pend_slot_next = 1'b0;
        bypass_next    = bypass_reg;
        last_bar_next  = last_bar_reg;
        val_next       = val_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_base_reg + AW'(bar_reg);
        ram_wdata      = div_q;
        ram_raddr      = addr_reg;
        div_start      = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (32'(clr_addr_reg) == DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    val_next      = in_val;
                    bar_next      = in_idx;
                    bypass_next   = (k_eff == KW'(1)) || (32'(in_idx) >= 32'(NUM_BARS));
                    last_bar_next = 32'(in_idx) == NUM_BARS - 1;
                    addr_next     = AW'(in_idx);
                    n_next        = '0;
                    sum_next      = '0;
                    if ((k_eff == KW'(1)) || (32'(in_idx) >= 32'(NUM_BARS)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (n_reg != k_eff)
                begin
                    pend_next      = 1'b1;
                    pend_slot_next = n_reg == KW'(slot_reg);
                    addr_next      = addr_reg + AW'(NUM_BARS);
                    n_next         = n_reg + KW'(1);
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(pend_slot_reg ? val_reg : ram_rdata);
                end
                if (n_reg == k_eff && !pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (bypass_reg)
                    begin
                        out_data_next = val_reg;
                    end
                    else
                    begin
                        out_data_next = div_q;
                        ram_we        = 1'b1;
                        if (last_bar_reg)
                        begin
                            if (KW'(slot_reg) + KW'(1) < k_eff)
                            begin
                                slot_next      = slot_reg + SW'(1);
                                slot_base_next = slot_base_reg + AW'(NUM_BARS);
                            end
                            else
                            begin
                                slot_next      = '0;
                                slot_base_next = '0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cfg_reg       <= CFG_W'(1);
            slot_reg      <= '0;
            slot_base_reg <= '0;
            clr_addr_reg  <= '0;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            slot_reg      <= slot_next;
            slot_base_reg <= slot_base_next;
            clr_addr_reg  <= clr_addr_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        bar_reg       <= bar_next;
        pend_slot_reg <= pend_slot_next;
        bypass_reg    <= bypass_next;
        last_bar_reg  <= last_bar_next;
        val_reg       <= val_next;
        sum_reg       <= sum_next;
        out_data_reg  <= out_data_next;
    end

    pbfas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pbfas_div #(
        .SUM_W (SUM_W),
        .KW    (KW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (k_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < MAX_FRAMES)
        else $error("frame slot out of range");

    a_slot_base: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_base_reg) == 32'(slot_reg) * NUM_BARS)
        else $error("slot base does not match frame slot");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_DONE))
        else $error("history write outside clear or write-back");

endmodule

### src/pbfas_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module pbfas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/pbfas_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pbfas_div #(
    parameter int SUM_W = 12,
    parameter int KW    = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_W-1:0]           dividend,
    input  logic [KW-1:0]              divisor,
    output logic                       done,
    output logic [pbfas_pkg::VAL_W-1:0] quotient
);

    import pbfas_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [KW-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [KW:0]      trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[SUM_W-1]};
        ge        = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SUM_W);
            rem_next  = '0;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? KW'(trial - {1'b0, divisor}) : trial[KW-1:0];
            dq_next  = {dq_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg[VAL_W-1:0];

endmodule
